// File: rtl/core/fcr_pkg.sv
// Shared types, constants and reply table for the framed command receiver.
package fcr_pkg;

  localparam int NUM_CODES = 7;
  localparam int REPLY_LEN = 11;
  localparam int BEAT_W    = 4;
  localparam int CFG_ADDR_W = 3;

  localparam logic [1:0] OP_RX       = 2'd0;
  localparam logic [1:0] OP_CLR_TIME = 2'd1;
  localparam logic [1:0] OP_CLR_DL   = 2'd2;

  localparam logic [2:0] FLD_NONE   = 3'd0;
  localparam logic [2:0] FLD_SECOND = 3'd7;

  localparam logic [7:0]  HEAD_A    = 8'hFF;
  localparam logic [7:0]  HEAD_B    = 8'h55;
  localparam logic [7:0]  MARK_BYTE = 8'h7F;
  localparam logic [15:0] REPLY_CMD = 16'h3F3F;
  localparam logic [2:0]  MARK_RUN_MAX = 3'd5;

  localparam logic [7:0] R2_MASK_A = 8'h5A;
  localparam logic [7:0] R2_MASK_B = 8'hA5;
  localparam logic [7:0] R3_MASK   = 8'h57;

  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(REPLY_LEN - 1);

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_HEAD = 6'b000010,
    PH_CMDH = 6'b000100,
    PH_CMDL = 6'b001000,
    PH_LEN  = 6'b010000,
    PH_PAY  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        reply;
    logic [7:0]  r2;
    logic [7:0]  r3;
    logic        done;
    logic [2:0]  fld;
    logic [15:0] val;
    logic        tflag;
    logic        dl;
  } desc_t;

  function automatic logic [7:0] reply_byte(logic [BEAT_W-1:0] idx, logic [7:0] r2,
                                            logic [7:0] r3);
    logic [7:0] b;
    case (idx)
      4'd0:    b = HEAD_A;
      4'd1:    b = HEAD_B;
      4'd2:    b = r2;
      4'd3:    b = r3;
      4'd4:    b = 8'h06;
      4'd5:    b = 8'h4D;
      4'd6:    b = 8'h61;
      4'd7:    b = 8'h72;
      4'd8:    b = 8'h6B;
      4'd9:    b = 8'h54;
      4'd10:   b = 8'h43;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/fcr_if.sv
// Channel interfaces for input bytes, results and configuration writes.
interface fcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;
  modport source (output valid, opcode, rx_byte, input ready);
  modport sink   (input valid, opcode, rx_byte, output ready);
endinterface

interface fcr_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        last;
  logic        frame_done;
  logic [2:0]  field_written;
  logic [15:0] field_value;
  logic        time_flag;
  logic        download_request;
  modport source (output valid, tx_valid, tx_byte, last, frame_done, field_written,
                  field_value, time_flag, download_request, input ready);
  modport sink   (input valid, tx_valid, tx_byte, last, frame_done, field_written,
                  field_value, time_flag, download_request, output ready);
endinterface

interface fcr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fcr_pkg::CFG_ADDR_W-1:0]   addr;
  logic [15:0]                      data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/core/framed_command_receiver_top.sv
// Framed command receiver: parses FF 55 frames, reports time field writes and replies.
// Each accepted transaction updates the parser in the cycle it is accepted and yields
// one result, or eleven reply results for command 3F3F, via the descriptor register
// and then the result register. A new transaction is taken every cycle while results
// flow freely; a reply holds the result register until its eleven bytes are taken, and
// one more transaction can wait in the descriptor register before input ready drops.
module framed_command_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  fcr_in_if.sink      in_chan,
  fcr_out_if.source   out_chan,
  fcr_cfg_if.sink     cfg_chan
);

  logic [15:0] codes_r [fcr_pkg::NUM_CODES];

  fcr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] cmd_hi_r, cmd_hi_nxt;
  logic [7:0] cmd_lo_r, cmd_lo_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] p0_r, p0_nxt;
  logic [7:0] p1_r, p1_nxt;
  logic       pause_r, pause_nxt;
  logic [2:0] marks_r, marks_nxt;
  logic       dl_r, dl_nxt;

  fcr_pkg::desc_t desc_nxt, d_r, a_r;
  logic           d_v_r, a_v_r;
  logic [fcr_pkg::BEAT_W-1:0] beat_r;

  logic        in_fire, out_fire, out_last, move;
  logic        done;
  logic [15:0] cmd;
  logic [8:0]  cnt_inc;
  logic [2:0]  fld;

  // Configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fcr_pkg::NUM_CODES; i++) begin
        codes_r[i] <= 16'(i + 1);
      end
    end else if (cfg_chan.valid && cfg_chan.addr < 3'(fcr_pkg::NUM_CODES)) begin
      codes_r[cfg_chan.addr] <= cfg_chan.data;
    end
  end

  // Handshakes
  assign out_last = !a_r.reply || beat_r == fcr_pkg::LAST_BEAT;
  assign out_fire = out_chan.valid && out_chan.ready;
  assign move     = !a_v_r || (out_fire && out_last);
  assign in_chan.ready = !d_v_r || move;
  assign in_fire  = in_chan.valid && in_chan.ready;

  // Parser next state
  always_comb begin
    phase_nxt  = phase_r;
    cmd_hi_nxt = cmd_hi_r;
    cmd_lo_nxt = cmd_lo_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    p0_nxt     = p0_r;
    p1_nxt     = p1_r;
    pause_nxt  = pause_r;
    marks_nxt  = marks_r;
    dl_nxt     = dl_r;
    done       = 1'b0;
    cnt_inc    = {1'b0, cnt_r} + 9'd1;
    cmd        = {cmd_hi_r, cmd_lo_r};
    fld        = fcr_pkg::FLD_NONE;

    case (in_chan.opcode)
      fcr_pkg::OP_CLR_TIME: begin
        pause_nxt = 1'b0;
      end
      fcr_pkg::OP_CLR_DL: begin
        dl_nxt = 1'b0;
      end
      fcr_pkg::OP_RX: begin
        if (in_chan.rx_byte == fcr_pkg::MARK_BYTE) begin
          if (marks_r >= fcr_pkg::MARK_RUN_MAX) begin
            marks_nxt = 3'd0;
            dl_nxt    = 1'b1;
          end else begin
            marks_nxt = marks_r + 3'd1;
          end
        end else begin
          marks_nxt = 3'd0;
        end

        if (!pause_r) begin
          case (phase_r)
            fcr_pkg::PH_HEAD: begin
              phase_nxt = (in_chan.rx_byte == fcr_pkg::HEAD_B) ? fcr_pkg::PH_CMDH
                                                               : fcr_pkg::PH_HUNT;
            end
            fcr_pkg::PH_CMDH: begin
              cmd_hi_nxt = in_chan.rx_byte;
              phase_nxt  = fcr_pkg::PH_CMDL;
            end
            fcr_pkg::PH_CMDL: begin
              cmd_lo_nxt = in_chan.rx_byte;
              phase_nxt  = fcr_pkg::PH_LEN;
            end
            fcr_pkg::PH_LEN: begin
              len_nxt   = in_chan.rx_byte;
              cnt_nxt   = 8'd0;
              phase_nxt = fcr_pkg::PH_PAY;
            end
            fcr_pkg::PH_PAY: begin
              if (cnt_r == 8'd0) begin
                p0_nxt = in_chan.rx_byte;
              end else if (cnt_r == 8'd1) begin
                p1_nxt = in_chan.rx_byte;
              end
              cnt_nxt = cnt_inc[7:0];
              if (cnt_inc >= {1'b0, len_r}) begin
                phase_nxt = fcr_pkg::PH_HUNT;
                cnt_nxt   = 8'd0;
                done      = 1'b1;
              end
            end
            default: begin
              phase_nxt = (in_chan.rx_byte == fcr_pkg::HEAD_A) ? fcr_pkg::PH_HEAD
                                                               : fcr_pkg::PH_HUNT;
            end
          endcase

          if (done) begin
            for (int i = fcr_pkg::NUM_CODES - 1; i >= 0; i--) begin
              if (codes_r[i] == cmd) begin
                fld = 3'(i + 1);
              end
            end
            if (fld == fcr_pkg::FLD_SECOND) begin
              pause_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    desc_nxt.reply = done && fld == fcr_pkg::FLD_NONE && cmd == fcr_pkg::REPLY_CMD;
    desc_nxt.r2    = (p0_nxt & fcr_pkg::R2_MASK_A) | (p1_nxt & fcr_pkg::R2_MASK_B);
    desc_nxt.r3    = (p0_nxt ^ fcr_pkg::R3_MASK) | (p1_nxt & fcr_pkg::R3_MASK);
    desc_nxt.done  = done;
    desc_nxt.fld   = fld;
    desc_nxt.val   = (fld == fcr_pkg::FLD_NONE) ? 16'd0 : {p0_nxt, p1_nxt};
    desc_nxt.tflag = pause_nxt;
    desc_nxt.dl    = dl_nxt;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fcr_pkg::PH_HUNT;
      cmd_hi_r <= 8'd0;
      cmd_lo_r <= 8'd0;
      len_r    <= 8'd0;
      cnt_r    <= 8'd0;
      p0_r     <= 8'd0;
      p1_r     <= 8'd0;
      pause_r  <= 1'b0;
      marks_r  <= 3'd0;
      dl_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      cmd_hi_r <= cmd_hi_nxt;
      cmd_lo_r <= cmd_lo_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      p0_r     <= p0_nxt;
      p1_r     <= p1_nxt;
      pause_r  <= pause_nxt;
      marks_r  <= marks_nxt;
      dl_r     <= dl_nxt;
    end
  end

  // Descriptor register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r  <= 1'b0;
      a_v_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      if (in_fire) begin
        d_v_r <= 1'b1;
      end else if (move) begin
        d_v_r <= 1'b0;
      end
      if (move) begin
        a_v_r  <= d_v_r;
        beat_r <= '0;
      end else if (out_fire) begin
        beat_r <= beat_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      d_r <= desc_nxt;
    end
    if (move && d_v_r) begin
      a_r <= d_r;
    end
  end

  // Result fields
  assign out_chan.valid            = a_v_r;
  assign out_chan.tx_valid         = a_r.reply;
  assign out_chan.tx_byte          = a_r.reply ? fcr_pkg::reply_byte(beat_r, a_r.r2, a_r.r3)
                                               : 8'd0;
  assign out_chan.last             = out_last;
  assign out_chan.frame_done       = a_r.done;
  assign out_chan.field_written    = a_r.fld;
  assign out_chan.field_value      = a_r.val;
  assign out_chan.time_flag        = a_r.tflag;
  assign out_chan.download_request = a_r.dl;

  a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r |-> beat_r <= fcr_pkg::LAST_BEAT)
    else $error("reply beat counter past last byte");

  a_beat_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last |=> beat_r == $past(beat_r) + 1'b1 && a_v_r)
    else $error("reply beat did not advance");

  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> d_v_r)
    else $error("accepted transaction not held");

  a_second_pauses: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && a_r.fld == fcr_pkg::FLD_SECOND |-> a_r.tflag)
    else $error("seconds write without pause flag");

  a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
    a_v_r && a_r.reply |-> a_r.done && a_r.fld == fcr_pkg::FLD_NONE && a_r.val == 16'd0)
    else $error("reply carries a field write");

endmodule
